FILE: rtl/core/rfc_pkg.sv
// shared types and constants of the front-to-back ray compositor
package rfc_pkg;

    localparam int VALUE_W   = 32;
    localparam int SCALE_W   = 32;
    localparam int COUNT_W   = 9;
    localparam int OP_W      = 17;
    localparam int COLOR_W   = 24;
    localparam int ENTRY_W   = OP_W + COLOR_W;
    localparam int EIDX_W    = 8;
    localparam int ACC_W     = 25;
    localparam int PIXEL_W   = 32;
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int FLAGS_W   = 3;

    localparam logic [OP_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [OP_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [7:0]      CH_MAX   = 8'hFF;

    localparam int QUEUE_DEPTH = 4;

    // register map, word index on paddr[3:2]
    localparam logic [1:0] REG_RANGE_MIN   = 2'd0;
    localparam logic [1:0] REG_RANGE_SCALE = 2'd1;
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;
    localparam logic [1:0] REG_OPAQUE_THR  = 2'd3;

    // kind bits of one queued item
    typedef struct packed {
        logic is_write;
        logic flag;      // sample: value mappable, write: index inside the table
        logic last;
    } rfc_flags_t;

    // value-to-index mapping settings
    typedef struct packed {
        logic [VALUE_W-1:0] range_min;
        logic [SCALE_W-1:0] range_scale;
        logic [COUNT_W-1:0] entry_count;
    } rfc_map_cfg_t;

endpackage

FILE: rtl/core/rfc_queue.sv
// short queue between the classifying front and the compositing back
module rfc_queue import rfc_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> !full)
        else $error("queue still full after a pop");

endmodule

FILE: rtl/core/rfc_front.sv
// input side: accepts beats, maps sample values to table indexes, feeds the queue
module rfc_front import rfc_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int QW = FLAGS_W + AW + ENTRY_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfc_map_cfg_t         map_cfg,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // sample_value 31:0, entry_index 39:32, entry_color 63:40, entry_opacity 80:64
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type 0, sample_valid 1
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 q_push,
    output logic [QW-1:0]        q_item,
    input  logic                 q_full
);

    logic                 adv;
    logic [VALUE_W:0]     diff;

    logic                 s1_valid_reg, s1_valid_next;
    rfc_flags_t           s1_flags_reg;
    logic [VALUE_W:0]     s1_diff_reg;
    logic [EIDX_W-1:0]    s1_eidx_reg;
    logic [ENTRY_W-1:0]   s1_entry_reg;

    logic                 s2_valid_reg, s2_valid_next;
    rfc_flags_t           s2_flags_reg;
    logic                 s2_pos_reg;
    logic [31:0]          s2_hi_reg;
    logic [EIDX_W-1:0]    s2_eidx_reg;
    logic [ENTRY_W-1:0]   s2_entry_reg;

    logic [63:0]          prod;
    logic [31:0]          cnt32;
    logic [31:0]          last32;
    logic [31:0]          idx32;
    rfc_flags_t           out_flags;
    logic [AW-1:0]        out_addr;
    logic [ENTRY_W-1:0]   out_data;

    assign adv           = !s2_valid_reg || !q_full;
    assign s_axis_tready = adv;
    assign q_push        = s2_valid_reg && !q_full;

    assign diff = {s_axis_tdata[VALUE_W-1], s_axis_tdata[VALUE_W-1:0]}
                - {map_cfg.range_min[VALUE_W-1], map_cfg.range_min};
    assign prod = 64'(s1_diff_reg[VALUE_W-1:0]) * 64'(map_cfg.range_scale);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (adv)
        begin
            s1_valid_next = s_axis_tvalid;
            s2_valid_next = s1_valid_reg;
        end
    end

    // index clamp to the entries in use; table writes pass their index and an in-table flag
    always_comb
    begin
        cnt32 = 32'(map_cfg.entry_count);
        if (cnt32 > 32'(TABLE_DEPTH))
        begin
            cnt32 = 32'(TABLE_DEPTH);
        end
        last32 = (cnt32 == '0) ? '0 : cnt32 - 32'd1;
        idx32  = '0;
        if (s2_pos_reg)
        begin
            idx32 = (s2_hi_reg > last32) ? last32 : s2_hi_reg;
        end
        out_flags = s2_flags_reg;
        if (s2_flags_reg.is_write)
        begin
            out_flags.flag = (32'(s2_eidx_reg) < 32'(TABLE_DEPTH));
            out_addr       = AW'(s2_eidx_reg);
            out_data       = s2_entry_reg;
        end
        else
        begin
            out_addr = idx32[AW-1:0];
            out_data = '0;
        end
    end

    assign q_item = {out_flags, out_addr, out_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_flags_reg.is_write <= s_axis_tuser[0];
            s1_flags_reg.flag     <= s_axis_tuser[1];
            s1_flags_reg.last     <= s_axis_tlast;
            s1_diff_reg           <= diff;
            s1_eidx_reg           <= s_axis_tdata[39:32];
            s1_entry_reg          <= {s_axis_tdata[80:64], s_axis_tdata[63:40]};

            s2_flags_reg <= s1_flags_reg;
            s2_pos_reg   <= !s1_diff_reg[VALUE_W] && (s1_diff_reg != '0);
            s2_hi_reg    <= prod[63:32];
            s2_eidx_reg  <= s1_eidx_reg;
            s2_entry_reg <= s1_entry_reg;
        end
    end

endmodule

FILE: rtl/core/rfc_back.sv
// compositing side: transfer table, alpha recurrence and pixel output register
module rfc_back import rfc_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int QW = FLAGS_W + AW + ENTRY_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [OP_W-1:0]    opaque_threshold,
    input  logic               q_empty,
    input  logic [QW-1:0]      q_head,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // pixel_argb 31:0
    output logic [PIXEL_W-1:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_ACCUM  = 4'b0100,
        ST_PACK   = 4'b1000
    } state_t;

    function automatic logic [7:0] to_channel(input logic [25:0] sum);
        logic [9:0] c;
        c = sum[25:16];
        return (c > 10'(CH_MAX)) ? CH_MAX : c[7:0];
    endfunction

    logic [ENTRY_W-1:0] tf_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic               last_reg, last_next;
    logic               sat_reg, sat_next;
    logic [OP_W-1:0]    acc_alpha_reg, acc_alpha_next;
    logic [ACC_W-1:0]   acc_red_reg, acc_red_next;
    logic [ACC_W-1:0]   acc_green_reg, acc_green_next;
    logic [ACC_W-1:0]   acc_blue_reg, acc_blue_next;
    logic [OP_W-1:0]    weight_reg, weight_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] pixel_reg, pixel_next;

    rfc_flags_t         head_flags;
    logic [AW-1:0]      head_addr;
    logic [ENTRY_W-1:0] head_data;
    logic               mem_we;
    logic               mem_re;
    logic               out_free;

    logic [OP_W-1:0]    op;
    logic [OP_W-1:0]    inv_alpha;
    logic [33:0]        wprod;
    logic [34:0]        wsum;
    logic [17:0]        alpha_sum;
    logic [OP_W-1:0]    alpha_new;
    logic [25:0]        a_scaled;

    assign head_flags = q_head[QW-1 -: FLAGS_W];
    assign head_addr  = q_head[ENTRY_W +: AW];
    assign head_data  = q_head[ENTRY_W-1:0];
    assign out_free   = !out_valid_reg || m_axis_tready;

    // weight = ((1 - alpha) * opacity) rounded half up
    assign op        = (rd_data_reg[ENTRY_W-1 -: OP_W] > ONE_Q16)
                     ? ONE_Q16 : rd_data_reg[ENTRY_W-1 -: OP_W];
    assign inv_alpha = ONE_Q16 - acc_alpha_reg;
    assign wprod     = 34'(inv_alpha) * 34'(op);
    assign wsum      = 35'(wprod) + 35'(HALF_Q16);

    assign alpha_sum = 18'(acc_alpha_reg) + 18'(weight_reg);
    assign alpha_new = (alpha_sum > 18'(ONE_Q16)) ? ONE_Q16 : alpha_sum[OP_W-1:0];
    assign a_scaled  = 26'(acc_alpha_reg) * 26'(CH_MAX) + 26'(HALF_Q16);

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        sat_next       = sat_reg;
        acc_alpha_next = acc_alpha_reg;
        acc_red_next   = acc_red_reg;
        acc_green_next = acc_green_reg;
        acc_blue_next  = acc_blue_reg;
        weight_next    = weight_reg;
        color_next     = color_reg;
        pixel_next     = pixel_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    last_next = head_flags.last;
                    if (head_flags.is_write)
                    begin
                        mem_we = head_flags.flag;
                    end
                    else if (head_flags.flag && !sat_reg)
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_LOOKUP;
                    end
                    else if (head_flags.last)
                    begin
                        state_next = ST_PACK;
                    end
                end
            end
            ST_LOOKUP:
            begin
                weight_next = wsum[32:16];
                color_next  = rd_data_reg[COLOR_W-1:0];
                if (op != '0)
                begin
                    state_next = ST_ACCUM;
                end
                else
                begin
                    state_next = last_reg ? ST_PACK : ST_IDLE;
                end
            end
            ST_ACCUM:
            begin
                acc_red_next   = acc_red_reg + 25'(weight_reg) * 25'(color_reg[23:16]);
                acc_green_next = acc_green_reg + 25'(weight_reg) * 25'(color_reg[15:8]);
                acc_blue_next  = acc_blue_reg + 25'(weight_reg) * 25'(color_reg[7:0]);
                acc_alpha_next = alpha_new;
                sat_next       = sat_reg || (alpha_new >= opaque_threshold);
                state_next     = last_reg ? ST_PACK : ST_IDLE;
            end
            ST_PACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = {to_channel(a_scaled),
                                      to_channel(26'(acc_red_reg) + 26'(HALF_Q16)),
                                      to_channel(26'(acc_green_reg) + 26'(HALF_Q16)),
                                      to_channel(26'(acc_blue_reg) + 26'(HALF_Q16))};
                    acc_alpha_next = '0;
                    acc_red_next   = '0;
                    acc_green_next = '0;
                    acc_blue_next  = '0;
                    sat_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            acc_alpha_reg <= '0;
            acc_red_reg   <= '0;
            acc_green_reg <= '0;
            acc_blue_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            sat_reg       <= sat_next;
            acc_alpha_reg <= acc_alpha_next;
            acc_red_reg   <= acc_red_next;
            acc_green_reg <= acc_green_next;
            acc_blue_reg  <= acc_blue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        color_reg  <= color_next;
        pixel_reg  <= pixel_next;
    end

    // transfer table, one port: write or registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tf_mem[head_addr] <= head_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= tf_mem[head_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pixel_reg;

    a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_alpha_reg <= ONE_Q16)
        else $error("accumulated alpha above one");
    a_pack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PACK && out_free) |=> (acc_alpha_reg == '0 && !sat_reg && out_valid_reg))
        else $error("pixel emit did not clear the ray");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while a sample is in work");

endmodule

FILE: rtl/core/ray_front_to_back_compositor.sv
// top level of the front-to-back ray compositor with transfer table lookup
// path: a composited last sample passes s1, s2, the queue, IDLE, LOOKUP, ACCUM, PACK to tvalid
// throughput: 1 beat per cycle in until the 4-entry queue fills; back pops only in IDLE;
//   a zero-opacity sample adds LOOKUP, a composited one LOOKUP and ACCUM, a last one PACK
// reset: clears pipeline, queue, ray accumulators and output valid; registers take their
//   defaults; the transfer table is undefined until written, no clearing pass
module ray_front_to_back_compositor import rfc_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // input beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // sample_value 31:0, entry_index 39:32, entry_color 63:40, entry_opacity 80:64
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type 0, sample_valid 1
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    // pixel beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel_argb 31:0
    output logic [PIXEL_W-1:0]   m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QW = FLAGS_W + AW + ENTRY_W;

    // configuration registers
    logic [VALUE_W-1:0] range_min_reg, range_min_next;
    logic [SCALE_W-1:0] range_scale_reg, range_scale_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [OP_W-1:0]    opaque_thr_reg, opaque_thr_next;
    logic               cfg_write;

    rfc_map_cfg_t       map_cfg;

    // queue between the two halves
    logic               q_push;
    logic [QW-1:0]      q_item;
    logic               q_full;
    logic               q_pop;
    logic [QW-1:0]      q_head;
    logic               q_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        range_min_next   = range_min_reg;
        range_scale_next = range_scale_reg;
        entry_count_next = entry_count_reg;
        opaque_thr_next  = opaque_thr_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_RANGE_MIN:   range_min_next   = pwdata;
                REG_RANGE_SCALE: range_scale_next = pwdata;
                REG_ENTRY_COUNT: entry_count_next = pwdata[COUNT_W-1:0];
                REG_OPAQUE_THR:  opaque_thr_next  = pwdata[OP_W-1:0];
                default:         range_min_next   = range_min_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_RANGE_MIN:   prdata = range_min_reg;
            REG_RANGE_SCALE: prdata = range_scale_reg;
            REG_ENTRY_COUNT: prdata = 32'(entry_count_reg);
            REG_OPAQUE_THR:  prdata = 32'(opaque_thr_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= '0;
            range_scale_reg <= 32'd65536;
            entry_count_reg <= 9'd256;
            opaque_thr_reg  <= 17'd65470;
        end
        else
        begin
            range_min_reg   <= range_min_next;
            range_scale_reg <= range_scale_next;
            entry_count_reg <= entry_count_next;
            opaque_thr_reg  <= opaque_thr_next;
        end
    end

    assign map_cfg.range_min   = range_min_reg;
    assign map_cfg.range_scale = range_scale_reg;
    assign map_cfg.entry_count = entry_count_reg;

    // front: accept, classify, map value to table index
    rfc_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .map_cfg       (map_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_push        (q_push),
        .q_item        (q_item),
        .q_full        (q_full)
    );

    // decoupling queue, lets either half stall on its own
    rfc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty)
    );

    // back: table writes, lookup, alpha recurrence, pixel emit
    rfc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .opaque_threshold (opaque_thr_reg),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata)
    );

endmodule

FILE: dv/tb_ray_front_to_back_compositor.sv
// self-checking testbench of the front-to-back ray compositor: directed and random rays against a predictor
module tb_ray_front_to_back_compositor;
    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    localparam int TABLE_SLOTS  = 256;
    // margin for the pixel path plus up to 4 queued beats
    localparam int DRAIN_CYCLES = 24;

    typedef longint unsigned u64_t;

    // request kind carried in tuser bit 0
    typedef enum logic {
        REQ_SAMPLE      = 1'b0,
        REQ_TABLE_WRITE = 1'b1
    } req_kind_t;

    // how the pixel side applies back-pressure
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PATTERN
    } ready_mode_t;

    // one input beat before packing
    typedef struct {
        req_kind_t          kind;
        logic [VALUE_W-1:0] value;
        logic               valid;
        logic               last;
        logic [EIDX_W-1:0]  eidx;
        logic [COLOR_W-1:0] color;
        logic [OP_W-1:0]    opacity;
    } ray_beat_t;

    // register contents used by the predictor
    typedef struct {
        logic signed [VALUE_W-1:0] range_min;
        logic [SCALE_W-1:0]        range_scale;
        logic [COUNT_W-1:0]        entry_count;
        logic [OP_W-1:0]           opaque_threshold;
    } map_setting_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // sample_value 31:0, entry_index 39:32, entry_color 63:40, entry_opacity 80:64
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // req_type 0, sample_valid 1
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // pixel_argb 31:0
    logic [PIXEL_W-1:0]   m_axis_tdata;

    ray_front_to_back_compositor #(
        .TABLE_DEPTH (TABLE_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: transfer table, ray accumulators, register copy
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] xfer_table [TABLE_SLOTS];
    int unsigned        ray_alpha = 0;
    int unsigned        ray_red = 0;
    int unsigned        ray_green = 0;
    int unsigned        ray_blue = 0;
    bit                 ray_opaque = 1'b0;
    map_setting_t       cfg = '{32'sd0, 32'd65536, 9'd256, 17'd65470};

    // expected pixels, oldest first
    logic [PIXEL_W-1:0] pixel_due [$];
    // beats waiting for the sender
    ray_beat_t          beat_backlog [$];
    ray_beat_t          beat_on_bus;

    int          fail_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          gap_max = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned stall_phase = 0;
    logic [PIXEL_W-1:0] pixel_want;

    // value to table entry: (value - min) * scale in Q16.16, upper 32 bits of the
    // exact product, clamped to the entries in use
    function automatic int unsigned table_slot(logic [VALUE_W-1:0] value);
        longint      diff;
        logic [64:0] prod;
        int unsigned top;
        top = (cfg.entry_count > TABLE_SLOTS) ? TABLE_SLOTS - 1 :
              ((cfg.entry_count > 0) ? cfg.entry_count - 1 : 0);
        diff = longint'($signed(value)) - longint'(cfg.range_min);
        if (diff <= 0)
            return 0;
        prod = 65'(diff) * 65'(cfg.range_scale);
        return (prod[64:32] > top) ? top : 32'(prod[64:32]);
    endfunction

    // round a Q16 sum to a byte, saturating at 255
    function automatic logic [7:0] round_channel(int unsigned acc);
        u64_t c;
        c = (u64_t'(acc) + 32768) >> 16;
        return (c > 255) ? CH_MAX : 8'(c);
    endfunction

    // apply one accepted beat; a last sample queues the expected pixel
    task automatic composite_beat(input ray_beat_t b);
        logic [ENTRY_W-1:0] entry;
        int unsigned        op;
        int unsigned        w;
        if (b.kind == REQ_TABLE_WRITE)
        begin
            // entry write, last flag has no effect
            xfer_table[b.eidx] = {b.opacity, b.color};
        end
        else
        begin
            if (b.valid && !ray_opaque)
            begin
                entry = xfer_table[table_slot(b.value)];
                op = entry[ENTRY_W-1:COLOR_W];
                if (op > ONE_Q16)
                    op = ONE_Q16;
                // zero opacity leaves the ray untouched
                if (op != 0)
                begin
                    w = 32'((u64_t'(ONE_Q16 - ray_alpha) * op + 32768) >> 16);
                    ray_red   += w * entry[23:16];
                    ray_green += w * entry[15:8];
                    ray_blue  += w * entry[7:0];
                    ray_alpha += w;
                    if (ray_alpha > ONE_Q16)
                        ray_alpha = ONE_Q16;
                    if (ray_alpha >= cfg.opaque_threshold)
                        ray_opaque = 1'b1;
                end
            end
            // a last sample emits even when invalid or after saturation
            if (b.last)
            begin
                pixel_due.push_back({round_channel(ray_alpha * 255), round_channel(ray_red),
                                     round_channel(ray_green), round_channel(ray_blue)});
                ray_alpha  = 0;
                ray_red    = 0;
                ray_green  = 0;
                ray_blue   = 0;
                ray_opaque = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of beats with random gaps, predictor fed on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                composite_beat(beat_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0 || beat_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    beat_on_bus = beat_backlog.pop_front();
                    s_axis_tdata  <= {7'd0, beat_on_bus.opacity, beat_on_bus.color,
                                      beat_on_bus.eidx, beat_on_bus.value};
                    s_axis_tuser  <= {beat_on_bus.valid, beat_on_bus.kind};
                    s_axis_tlast  <= beat_on_bus.last;
                    s_axis_tvalid <= 1'b1;
                    // end of burst: pick the next burst length and the gap before it
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(0, gap_max);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: pixel check against the oldest expectation, ready pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_due.size() == 0)
            begin
                $display("%0t pixel with nothing expected: expected none, actual %08h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                pixel_want = pixel_due.pop_front();
                if (m_axis_tdata !== pixel_want)
                begin
                    $display("%0t pixel_argb mismatch: expected %08h, actual %08h",
                             $time, pixel_want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
        stall_phase++;
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:      m_axis_tready <= ((stall_phase % 11) < 6);
        endcase
    end

    // ------------------------------------------------------------------
    // register port: setup then access, write lands at the access edge
    // ------------------------------------------------------------------
    task automatic reg_access(input logic [1:0] idx, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write all four registers, then read them back
    task automatic program_setting(input map_setting_t s);
        logic [1:0]  regs [4] = '{REG_RANGE_MIN, REG_RANGE_SCALE, REG_ENTRY_COUNT,
                                  REG_OPAQUE_THR};
        logic [31:0] words [4];
        logic [31:0] readback;
        words = '{s.range_min, s.range_scale, 32'(s.entry_count), 32'(s.opaque_threshold)};
        for (int r = 0; r < 4; r++)
            reg_access(regs[r], 1'b1, words[r], readback);
        cfg = s;
        for (int r = 0; r < 4; r++)
        begin
            reg_access(regs[r], 1'b0, '0, readback);
            if (readback !== words[r])
            begin
                $display("%0t register %0d readback mismatch: expected %08h, actual %08h",
                         $time, regs[r], words[r], readback);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // unused sample fields carry random bits, the block must ignore them
    task automatic queue_table_write(input logic [EIDX_W-1:0] eidx,
                                     input logic [COLOR_W-1:0] color,
                                     input logic [OP_W-1:0] opacity, input logic last);
        ray_beat_t b;
        b.kind    = REQ_TABLE_WRITE;
        b.value   = $urandom;
        b.valid   = 1'($urandom);
        b.last    = last;
        b.eidx    = eidx;
        b.color   = color;
        b.opacity = opacity;
        beat_backlog.push_back(b);
    endtask

    task automatic queue_sample(input logic [VALUE_W-1:0] value, input logic valid,
                                input logic last);
        ray_beat_t b;
        b.kind    = REQ_SAMPLE;
        b.value   = value;
        b.valid   = valid;
        b.last    = last;
        b.eidx    = 8'($urandom);
        b.color   = 24'($urandom);
        b.opacity = 17'($urandom);
        beat_backlog.push_back(b);
    endtask

    // zero, exactly one, above one, or a plain fraction
    function automatic logic [OP_W-1:0] random_opacity();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(1, 65535));
        endcase
    endfunction

    // mostly values that land inside the mapped range of the current setting
    function automatic logic [VALUE_W-1:0] pick_value();
        longint reach;
        longint base;
        base = longint'(cfg.range_min);
        if (cfg.range_scale == 0)
            reach = 64'sh7FFF_FFFF;
        else
            reach = ((longint'(cfg.entry_count) + 1) <<< 32) / longint'(cfg.range_scale);
        if (reach > 64'sh7FFF_FFFF)
            reach = 64'sh7FFF_FFFF;
        if (reach < 1)
            reach = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 32'(base + longint'($urandom_range(0, 32'(reach))));
            6:       return 32'(base - longint'($urandom_range(0, 131072)));
            7:       return $urandom;
            8:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'(base + longint'($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    // whole rays with random content, table rewrites mixed in, some noise rays
    task automatic queue_random_rays(input int n_beats);
        int made;
        int ray_len;
        bit noise;
        made = 0;
        while (made < n_beats)
        begin
            ray_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 8);
            noise = ($urandom_range(0, 15) == 0);
            for (int i = 0; i < ray_len; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    queue_table_write(8'($urandom), 24'($urandom), random_opacity(),
                                      1'($urandom));
                    made++;
                end
                queue_sample(noise ? 32'($urandom) : pick_value(),
                             $urandom_range(0, 7) != 0, i == ray_len - 1);
                made++;
            end
        end
    endtask

    // idle means nothing left to send, nothing on the bus and no pixel owed;
    // then give the back end time to retire pixel-less beats
    task automatic wait_idle();
        do
            @(negedge clk);
        while (beat_backlog.size() != 0 || s_axis_tvalid || pixel_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        map_setting_t plan [8];
        // explicit reset values
        plan[0] = '{32'sd0, 32'd65536, 9'd256, 17'd65470};
        // most negative min, widest scale, two entries, stop on first hit
        plan[1] = '{32'sh8000_0000, 32'hFFFF_FFFF, 9'd2, 17'd0};
        // most positive min, zero scale, count of zero, threshold exactly one
        plan[2] = '{32'sh7FFF_FFFF, 32'd0, 9'd0, 17'd65536};
        // -16.0 up, 8 entries per unit, threshold never reached
        plan[3] = '{32'shFFF0_0000, 32'h0008_0000, 9'd200, 17'h1FFFF};
        // count of one maps all to entry 0
        plan[4] = '{32'sd0, 32'h0010_0000, 9'd1, 17'd40000};
        // count above the table depth
        plan[5] = '{32'(-$urandom_range(0, 32'h0010_0000)), 32'h0004_0000, 9'h1FF, 17'd65535};
        plan[6] = '{32'($urandom), 32'($urandom_range(32'h1000, 32'h0040_0000)),
                    9'($urandom_range(2, 256)), 17'($urandom_range(30000, 65536))};
        plan[7] = '{32'sh0001_8000, 32'h00FF_0000, 9'd256, 17'd20000};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first stretch with no idling on either side, reset register values
        gap_max    = 0;
        ready_mode = READY_ALWAYS;

        // every entry written before any sample can read it
        for (int i = 0; i < TABLE_SLOTS; i++)
            queue_table_write(8'(i), 24'($urandom), random_opacity(), 1'($urandom));

        // directed entries, default mapping makes the index the integer part
        queue_table_write(8'd0, 24'hFFFFFF, '0, 1'b0);          // zero opacity
        queue_table_write(8'd1, 24'hFFFFFF, ONE_Q16, 1'b1);     // opaque white, last ignored
        queue_table_write(8'd2, 24'h000000, 17'h1FFFF, 1'b0);   // opacity above one
        queue_table_write(8'd3, 24'h123456, 17'd32768, 1'b0);   // half opacity
        queue_table_write(8'd255, 24'hFF00FF, 17'd1, 1'b0);     // faintest, last entry

        // empty ray closed by an invalid last sample
        queue_sample(32'h0000_0000, 1'b0, 1'b1);
        // zero-opacity entry only, sample skipped
        queue_sample(32'h0000_8000, 1'b1, 1'b1);
        // opaque hit saturates, later valid sample changes nothing, invalid last emits
        queue_sample(32'h0001_0000, 1'b1, 1'b0);
        queue_sample(32'h0003_0000, 1'b1, 1'b0);
        queue_sample(32'h0000_0000, 1'b0, 1'b1);
        // extremes of the value: below min goes to entry 0, top clamps to the last entry
        queue_sample(32'h8000_0000, 1'b1, 1'b0);
        queue_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
        // opacity above one counts as one
        queue_sample(32'h0002_FFFF, 1'b1, 1'b1);
        // repeated half-opacity hits, then the faint last entry
        queue_sample(32'h0003_0000, 1'b1, 1'b0);
        queue_sample(32'h0003_4000, 1'b1, 1'b0);
        queue_sample(32'h0003_FFFF, 1'b1, 1'b0);
        queue_sample(32'h00FF_0000, 1'b1, 1'b1);

        queue_random_rays(130);
        wait_idle();

        // one phase per register setting, idling varied between phases
        for (int p = 0; p < 8; p++)
        begin
            program_setting(plan[p]);
            @(negedge clk);
            gap_max    = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
            ready_mode = ready_mode_t'(p % 4);
            queue_random_rays(110);
            wait_idle();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
